FILE: hw/rtl/rned_pkg.sv
// rned_pkg: shared types, constants and the color distance function of the
// RGB neighborhood edge detector. No dependencies.
package rned_pkg;

    localparam int PIX_W      = 24;
    localparam int LB_W       = 2 * PIX_W;   // both line buffers side by side
    localparam int DIST_W     = 18;          // 3 * 255^2 fits in 18 bits
    localparam int LIM_W      = 19;          // (511 + 1)^2 fits in 19 bits

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int RST_WIDTH      = 2048;
    localparam int RST_HEIGHT     = 4096;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

    // result kinds, in emission order: center position inside the window
    localparam logic [1:0] RES_UL = 2'd0;   // window (1,1)
    localparam logic [1:0] RES_UR = 2'd1;   // window (1,2)
    localparam logic [1:0] RES_DL = 2'd2;   // window (2,1)
    localparam logic [1:0] RES_DR = 2'd3;   // window (2,2)

    localparam logic [PIX_W-1:0] COLOR_EDGE = 24'h000000;
    localparam logic [PIX_W-1:0] COLOR_FLAT = 24'hFFFFFF;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [8:0][PIX_W-1:0] t_window;   // index row*3 + col

    typedef struct packed {
        logic [1:0]       center_sel;
        logic             up_ok;
        logic             left_ok;
        logic             thr_neg;
        logic [LIM_W-1:0] lim;
    } t_cls_ctrl;

    // squared Euclidean RGB distance
    function automatic logic [DIST_W-1:0] sq_dist(input t_pix a, input t_pix b);
        logic [8:0]        d;
        logic [7:0]        m;
        logic [15:0]       sq;
        logic [DIST_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            d   = {1'b0, a[8*k +: 8]} - {1'b0, b[8*k +: 8]};
            m   = d[8] ? 8'(-d) : d[7:0];
            sq  = {8'd0, m} * {8'd0, m};
            acc = acc + DIST_W'(sq);
        end
        return acc;
    endfunction

endpackage

FILE: hw/rtl/rgb_neighborhood_edge_detect.sv
// rgb_neighborhood_edge_detect: 3x3 color distance edge detector, top level.
// Depends on rned_pkg, rned_line_buf and rned_classify.
//
// - Input (i_in_valid / o_in_stall / i_in_color): RGB pixels in raster order;
//   a transaction completes when valid is high and stall low.
// - Output (o_out_valid / i_out_stall / o_out_*): one classified pixel per
//   transaction, black with o_is_edge for an edge, white otherwise, with its
//   row and column; o_run_last marks the last result of an input.
// - A result leaves once all its in-frame neighbors have arrived: usually one
//   per input, up to four at the right column and bottom row, none for the
//   first row and first column.
// - Path: stage A, stage B, then the output register. Throughput: one pixel
//   per cycle while the receiver does not stall; an input causing n > 1
//   results holds the input off until stage B emits the last of them.
// - Stages: input/line-buffer read, window and result sequencing, output
//   register. The line buffer is one MAX_WIDTH x 48 memory.
// - Reset clears counters, valid flags and configuration (2048 x 4096,
//   threshold 0); line buffer content is read only for masked neighbors.
// - Receiver stall backs up into o_in_stall; nothing is lost or duplicated.
// - Width or height writes restart the frame. Configure only while idle.
module rgb_neighborhood_edge_detect
    import rned_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_in_color,
    // results
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_out_color,
    output logic                  o_is_edge,
    output logic [11:0]           o_out_row,
    output logic [10:0]           o_out_col,
    output logic                  o_run_last
);

    localparam int CW = $clog2(MAX_WIDTH);        // column counter
    localparam int RW = $clog2(MAX_HEIGHT);       // row counter
    localparam int WW = $clog2(MAX_WIDTH + 1);    // width register
    localparam int HW = $clog2(MAX_HEIGHT + 1);   // height register
    localparam int RST_W = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam int RST_H = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

    // ---------------- configuration ----------------
    logic [WW-1:0]    r_width;
    logic [HW-1:0]    r_height;
    logic             r_thr_neg;
    logic [LIM_W-1:0] r_lim;      // (threshold + 1)^2

    logic [11:0]      cfg_w;
    logic [12:0]      cfg_h;
    logic [9:0]       thr_p1;
    logic [19:0]      thr_sq;

    assign cfg_w  = i_cfg_data[11:0];
    assign cfg_h  = i_cfg_data[12:0];
    assign thr_p1 = 10'(i_cfg_data[8:0]) + 10'd1;
    assign thr_sq = thr_p1 * thr_p1;

    // ---------------- counters and handshake ----------------
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          in_acc;
    logic          last_col;
    logic          last_row;
    logic          cfg_restart;

    assign last_col    = (32'(r_col) + 32'd1) >= 32'(r_width);
    assign last_row    = (32'(r_row) + 32'd1) >= 32'(r_height);
    assign cfg_restart = i_cfg_we && ((i_cfg_idx == CFG_WIDTH) || (i_cfg_idx == CFG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WW'(RST_W);
            r_height  <= HW'(RST_H);
            r_thr_neg <= 1'b0;
            r_lim     <= LIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH: begin
                    if (cfg_w == '0) begin
                        r_width <= WW'(1);
                    end else if (32'(cfg_w) > 32'(MAX_WIDTH)) begin
                        r_width <= WW'(MAX_WIDTH);
                    end else begin
                        r_width <= WW'(cfg_w);
                    end
                end
                CFG_HEIGHT: begin
                    if (cfg_h == '0) begin
                        r_height <= HW'(1);
                    end else if (32'(cfg_h) > 32'(MAX_HEIGHT)) begin
                        r_height <= HW'(MAX_HEIGHT);
                    end else begin
                        r_height <= HW'(cfg_h);
                    end
                end
                CFG_THRESH: begin
                    r_thr_neg <= i_cfg_data[9];
                    r_lim     <= LIM_W'(thr_sq);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : RW'(r_row + RW'(1));
            end else begin
                r_col <= CW'(r_col + CW'(1));
            end
        end
    end

    // results this pixel completes, bit = result kind
    logic [3:0] in_mask;
    assign in_mask[RES_UL] = (r_row != '0) && (r_col != '0);
    assign in_mask[RES_UR] = (r_row != '0) && last_col;
    assign in_mask[RES_DL] = last_row && (r_col != '0);
    assign in_mask[RES_DR] = last_row && last_col;

    // ---------------- stage A: pixel + line buffer read ----------------
    logic            r_a_valid;
    t_pix            r_a_pix;
    logic [CW-1:0]   r_a_col;
    logic [RW-1:0]   r_a_row;
    logic [3:0]      r_a_mask;
    logic [LB_W-1:0] lb_rd;
    logic            a_move;
    logic            b_free;

    assign o_in_stall = r_a_valid && !b_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign a_move     = r_a_valid && b_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_pix  <= i_in_color;
            r_a_col  <= r_col;
            r_a_row  <= r_row;
            r_a_mask <= in_mask;
        end
    end

    // upper half: two rows above, lower half: one row above
    rned_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (a_move),
        .i_wr_addr (r_a_col),
        .i_wr_data ({lb_rd[PIX_W-1:0], r_a_pix}),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (lb_rd)
    );

    // ---------------- stage B: window and result sequencing ----------------
    t_window       r_win;
    logic [3:0]    r_b_mask;    // results still to emit
    logic [CW-1:0] r_b_col;
    logic [RW-1:0] r_b_row;
    logic          out_ready;
    logic [3:0]    emit_bit;
    logic [3:0]    b_rest;
    logic [1:0]    b_sel;
    logic          b_emit;

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= lb_rd[LB_W-1:PIX_W];
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= lb_rd[PIX_W-1:0];
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= r_a_pix;
            r_b_col  <= r_a_col;
            r_b_row  <= r_a_row;
        end
    end

    assign out_ready = !o_out_valid || !i_out_stall;
    assign emit_bit  = out_ready ? (r_b_mask & (~r_b_mask + 4'd1)) : 4'd0;
    assign b_rest    = r_b_mask & ~emit_bit;
    assign b_free    = (b_rest == '0);
    assign b_emit    = |emit_bit;

    always_comb begin
        priority if (r_b_mask[RES_UL]) begin
            b_sel = RES_UL;
        end else if (r_b_mask[RES_UR]) begin
            b_sel = RES_UR;
        end else if (r_b_mask[RES_DL]) begin
            b_sel = RES_DL;
        end else begin
            b_sel = RES_DR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_mask <= '0;
        end else if (a_move) begin
            r_b_mask <= r_a_mask;
        end else begin
            r_b_mask <= b_rest;
        end
    end

    // upper results sit one row up, left results one column left
    logic      sel_upper;
    logic      sel_right;
    t_cls_ctrl cls_ctrl;
    logic      cls_edge;

    assign sel_upper = !b_sel[1];
    assign sel_right = b_sel[0];

    assign cls_ctrl.center_sel = b_sel;
    assign cls_ctrl.up_ok      = sel_upper ? (32'(r_b_row) >= 32'd2) : (r_b_row != '0);
    assign cls_ctrl.left_ok    = sel_right ? (r_b_col != '0) : (32'(r_b_col) >= 32'd2);
    assign cls_ctrl.thr_neg    = r_thr_neg;
    assign cls_ctrl.lim        = r_lim;

    rned_classify u_classify (
        .i_window  (r_win),
        .i_ctrl    (cls_ctrl),
        .o_is_edge (cls_edge)
    );

    // ---------------- output register ----------------
    logic [RW-1:0] res_row;
    logic [CW-1:0] res_col;

    assign res_row = RW'(r_b_row - RW'(sel_upper));
    assign res_col = CW'(r_b_col - CW'(!sel_right));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (b_emit) begin
            o_out_valid <= 1'b1;
        end else if (out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_emit) begin
            o_out_color <= cls_edge ? COLOR_EDGE : COLOR_FLAT;
            o_is_edge   <= cls_edge;
            o_out_row   <= 12'(res_row);
            o_out_col   <= 11'(res_col);
            o_run_last  <= (b_rest == '0);
        end
    end

    // ---------------- assertions ----------------
    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(r_width))
        else $error("column counter beyond image width");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < 32'(r_height))
        else $error("row counter beyond image height");

    a_emit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(emit_bit))
        else $error("more than one result emitted in a cycle");

    a_accept_moves_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_a_valid) |-> a_move)
        else $error("input accepted over an occupied stage A");

    a_emit_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_emit |-> (r_b_mask != '0) && out_ready)
        else $error("result emitted without pending work or output room");

endmodule

FILE: hw/rtl/rned_line_buf.sv
// rned_line_buf: single-port-write, registered-read memory holding the two
// previous pixel rows. Depends on rned_pkg.
module rned_line_buf
    import rned_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  logic [LB_W-1:0] i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output logic [LB_W-1:0] o_rd_data
);

    logic [LB_W-1:0] r_mem [DEPTH];
    logic [LB_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // write-first on a same-address collision (one-pixel-wide frames)
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/rned_classify.sv
// rned_classify: edge decision for one window position against its in-frame
// 3x3 neighbors. Depends on rned_pkg (sq_dist, t_window, t_cls_ctrl).
module rned_classify
    import rned_pkg::*;
(
    input  t_window   i_window,
    input  t_cls_ctrl i_ctrl,
    output logic      o_is_edge
);

    logic [1:0] cr;
    logic [1:0] cc;
    t_pix       center;
    logic [8:0] near;
    logic [8:0] hit;

    always_comb begin
        unique case (i_ctrl.center_sel)
            RES_UL: begin cr = 2'd1; cc = 2'd1; center = i_window[4]; end
            RES_UR: begin cr = 2'd1; cc = 2'd2; center = i_window[5]; end
            RES_DL: begin cr = 2'd2; cc = 2'd1; center = i_window[7]; end
            default: begin cr = 2'd2; cc = 2'd2; center = i_window[8]; end
        endcase
    end

    for (genvar p = 0; p < 9; p++) begin : g_tap
        localparam int PR = p / 3;
        localparam int PC = p % 3;
        assign near[p] = (PR + 1 >= int'(cr)) && (PR <= int'(cr) + 1)
                      && (PC + 1 >= int'(cc)) && (PC <= int'(cc) + 1)
                      && !((PR < int'(cr)) && !i_ctrl.up_ok)
                      && !((PC < int'(cc)) && !i_ctrl.left_ok);
        // the center itself gives distance 0, below any limit
        assign hit[p] = near[p]
                     && ({1'b0, sq_dist(center, i_window[p])} >= i_ctrl.lim);
    end

    assign o_is_edge = i_ctrl.thr_neg || (|hit);

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for rgb_neighborhood_edge_detect, with an
// in-file predictor of the 3x3 color distance classification.
// Depends on rned_pkg and the rgb_neighborhood_edge_detect RTL.
module tb_top;
    import rned_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int MAX_W          = MAX_WIDTH_DEF;
    localparam int MAX_H          = MAX_HEIGHT_DEF;
    localparam int SETTLE_CYCLES  = 6;     // output register sits behind stages A and B
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off in the pressure phase
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
    localparam int RANDOM_PER_MODE = 30;
    localparam int SAT_PIXELS     = 12;    // partial frame after an oversized size write
    localparam int REPORT_LIMIT   = 10;

    // how the two sides idle during a phase
    typedef enum logic [2:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH,
        IDLE_HOLD
    } t_idle_mode;

    // one classified pixel as it leaves the output channel
    typedef struct packed {
        t_pix        color;
        logic        edge_flag;
        logic [11:0] row;
        logic [10:0] col;
        logic        last;
    } t_classified;

    // ------------------------------------------------------------------
    // DUT and its ports
    // ------------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = CFG_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_pix                  i_in_color = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_pix                  o_out_color;
    logic                  o_is_edge;
    logic [11:0]           o_out_row;
    logic [10:0]           o_out_col;
    logic                  o_run_last;

    rgb_neighborhood_edge_detect dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_color  (i_in_color),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_color (o_out_color),
        .o_is_edge   (o_is_edge),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_run_last  (o_run_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    t_pix        pixel_feed[$];      // pixels waiting for the driver
    t_classified edge_results[$];    // predicted classifications, oldest first
    int          pixels_sent    = 0; // pushed into pixel_feed
    int          pixels_taken   = 0; // input transactions seen
    int          mismatch_count = 0;
    t_idle_mode  idle_mode      = IDLE_NONE;

    // ------------------------------------------------------------------
    // Predictor state: own copy of line buffers, window, counters, config
    // ------------------------------------------------------------------
    t_pix line_up     [MAX_W];
    t_pix line_two_up [MAX_W];
    t_pix win         [9];          // row*3 + col, row 2 / col 2 newest
    int   cur_row, cur_col;
    int   frame_w, frame_h;
    int   thresh;

    function automatic int clamp_dim(input int v, input int maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic void predictor_reset();
        int k;
        for (k = 0; k < MAX_W; k++) begin
            line_up[k]     = '0;
            line_two_up[k] = '0;
        end
        for (k = 0; k < 9; k++) win[k] = '0;
        cur_row = 0;
        cur_col = 0;
        frame_w = RST_WIDTH;
        frame_h = RST_HEIGHT;
        thresh  = 0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_WIDTH: begin
                frame_w = clamp_dim(int'(data[11:0]), MAX_W);
                cur_row = 0;
                cur_col = 0;
            end
            CFG_HEIGHT: begin
                frame_h = clamp_dim(int'(data), MAX_H);
                cur_row = 0;
                cur_col = 0;
            end
            CFG_THRESH: thresh = int'($signed(data[9:0]));
            default: ;
        endcase
    endfunction

    function automatic int rgb_dist_sq(input t_pix a, input t_pix b);
        int d, acc, k;
        acc = 0;
        for (k = 0; k < 3; k++) begin
            d   = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
            acc = acc + d * d;
        end
        return acc;
    endfunction

    // floor(distance) > thresh  <=>  dist^2 >= (thresh+1)^2
    function automatic bit window_is_edge(input int cr, input int cc,
                                          input bit up_ok, input bit left_ok);
        int lim, r, c;
        if (thresh < 0) return 1'b1;
        lim = (thresh + 1) * (thresh + 1);
        for (r = cr - 1; r <= cr + 1; r++) begin
            for (c = cc - 1; c <= cc + 1; c++) begin
                if (r < 0 || r > 2 || c < 0 || c > 2) continue;
                if ((r < cr && !up_ok) || (c < cc && !left_ok)) continue;
                if (rgb_dist_sq(win[cr*3 + cc], win[r*3 + c]) >= lim) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_classified classified(input bit is_edge, input int row,
                                               input int col);
        t_classified res;
        res.color     = is_edge ? COLOR_EDGE : COLOR_FLAT;
        res.edge_flag = is_edge;
        res.row       = 12'(row);
        res.col       = 11'(col);
        res.last      = 1'b0;
        return res;
    endfunction

    // Move one pixel into the window and queue every classification it
    // completes, in raster order.
    function automatic void shift_in_pixel(input t_pix pix);
        t_classified res [4];
        int n, k, slot;
        bit end_col, end_row;
        n       = 0;
        slot    = cur_col % MAX_W;
        end_col = (cur_col + 1 >= frame_w);
        end_row = (cur_row + 1 >= frame_h);
        for (k = 0; k < 3; k++) begin
            win[3*k]     = win[3*k + 1];
            win[3*k + 1] = win[3*k + 2];
        end
        win[2]            = line_two_up[slot];
        win[5]            = line_up[slot];
        win[8]            = pix;
        line_two_up[slot] = line_up[slot];
        line_up[slot]     = pix;

        if (cur_row >= 1 && cur_col >= 1) begin
            res[n] = classified(window_is_edge(1, 1, cur_row >= 2, cur_col >= 2),
                                cur_row - 1, cur_col - 1);
            n++;
        end
        if (cur_row >= 1 && end_col) begin
            res[n] = classified(window_is_edge(1, 2, cur_row >= 2, cur_col >= 1),
                                cur_row - 1, cur_col);
            n++;
        end
        if (end_row && cur_col >= 1) begin
            res[n] = classified(window_is_edge(2, 1, cur_row >= 1, cur_col >= 2),
                                cur_row, cur_col - 1);
            n++;
        end
        if (end_row && end_col) begin
            res[n] = classified(window_is_edge(2, 2, cur_row >= 1, cur_col >= 1),
                                cur_row, cur_col);
            n++;
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (k = 0; k < n; k++) edge_results.push_back(res[k]);

        if (end_col) begin
            cur_col = 0;
            cur_row = end_row ? 0 : cur_row + 1;
        end else begin
            cur_col++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Idling decisions
    // ------------------------------------------------------------------
    function automatic bit send_gap(input t_idle_mode m);
        case (m)
            IDLE_SEND: return $urandom_range(0, 99) < 87;
            IDLE_BOTH: return $urandom_range(0, 99) < 31;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit recv_stall(input t_idle_mode m);
        case (m)
            IDLE_RECV: return $urandom_range(0, 99) < 87;
            IDLE_BOTH: return $urandom_range(0, 99) < 31;
            default:   return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers pixels from pixel_feed; a stalled transaction holds
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_color <= '0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pixel_feed.size() != 0 && !send_gap(idle_mode)) begin
                i_in_valid <= 1'b1;
                i_in_color <= pixel_feed.pop_front();
            end else begin
                i_in_valid <= 1'b0;
                i_in_color <= t_pix'($urandom());   // junk while idle
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall. In the pressure phase it holds off for HOLD_CYCLES
    // so the pipeline backs up into o_in_stall, then releases.
    // ------------------------------------------------------------------
    int hold_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_count  <= 0;
        end else if (idle_mode == IDLE_HOLD && hold_count < HOLD_CYCLES) begin
            i_out_stall <= 1'b1;
            hold_count  <= hold_count + 1;
        end else begin
            if (idle_mode != IDLE_HOLD) hold_count <= 0;
            i_out_stall <= recv_stall(idle_mode);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: tracks config writes and input transactions in the
    // predictor, checks every output transaction against the oldest
    // prediction.
    // ------------------------------------------------------------------
    function automatic void flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin
        t_classified got, want;
        if (!i_rst_n) begin
            predictor_reset();
        end else begin
            if (i_cfg_we) apply_reg(i_cfg_idx, i_cfg_data);

            if (i_in_valid && !o_in_stall) begin
                shift_in_pixel(i_in_color);
                pixels_taken++;
            end

            if (o_out_valid && !i_out_stall) begin
                got.color     = o_out_color;
                got.edge_flag = o_is_edge;
                got.row       = o_out_row;
                got.col       = o_out_col;
                got.last      = o_run_last;
                if (edge_results.size() == 0) begin
                    flag_error($sformatf({"unexpected result color=%06h edge=%0b",
                                          " row=%0d col=%0d last=%0b"},
                                         got.color, got.edge_flag, got.row, got.col,
                                         got.last));
                end else begin
                    want = edge_results.pop_front();
                    if (got.color !== want.color || got.edge_flag !== want.edge_flag ||
                        got.row !== want.row || got.col !== want.col ||
                        got.last !== want.last) begin
                        flag_error($sformatf({"mismatch: expected color=%06h edge=%0b row=%0d col=%0d",
                                              " last=%0b, got color=%06h edge=%0b row=%0d col=%0d",
                                              " last=%0b"},
                                             want.color, want.edge_flag, want.row, want.col,
                                             want.last, got.color, got.edge_flag, got.row,
                                             got.col, got.last));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transaction means the block hung
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("rgb_neighborhood_edge_detect regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Every pixel taken and every result out; then a settling wait for items
    // that produce nothing but may still be in the pipeline.
    task automatic wait_idle();
        while (!(pixels_taken == pixels_sent && edge_results.size() == 0))
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_mode(input t_idle_mode m);
        wait_idle();
        idle_mode <= m;
    endtask

    task automatic push_pixel(input t_pix c);
        pixel_feed.push_back(c);
        pixels_sent++;
    endtask

    // Mostly small variations around a base so that the threshold matters,
    // with fully random pixels mixed in.
    function automatic t_pix near_color(input t_pix base);
        t_pix c;
        int   v, k;
        if ($urandom_range(0, 3) == 0) return t_pix'($urandom());
        for (k = 0; k < 3; k++) begin
            v = int'(base[8*k +: 8]) + int'($urandom_range(0, 24)) - 12;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            c[8*k +: 8] = v[7:0];
        end
        return c;
    endfunction

    task automatic feed_pixels(input int n);
        t_pix base;
        int   k;
        base = t_pix'($urandom());
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) base = t_pix'($urandom());
            push_pixel(near_color(base));
        end
    endtask

    // negative (all edges), zero, the top, or a small useful value;
    // bits above the 10-bit field are don't-care
    function automatic logic [CFG_DATA_W-1:0] threshold_word();
        int t;
        case ($urandom_range(0, 7))
            0:       t = -int'($urandom_range(1, 512));
            1:       t = 511;
            2:       t = 0;
            default: t = $urandom_range(1, 30);
        endcase
        return {3'($urandom()), 10'(t)};
    endfunction

    // One random frame setup followed by whole, doubled or partial frames.
    // A partial frame is cut off by the next size write, which restarts it.
    task automatic random_segment();
        int w, h, n, split;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
        h = $urandom_range(1, 4);
        write_reg(CFG_WIDTH, {1'($urandom()), 12'(w)});
        write_reg(CFG_HEIGHT, 13'(h));
        write_reg(CFG_THRESH, threshold_word());
        n = w * h * $urandom_range(1, 2);
        if ($urandom_range(0, 4) == 0) n = $urandom_range(1, w * h);
        if (n > 1 && $urandom_range(0, 5) == 0) begin
            // threshold change in the middle of a frame
            split = $urandom_range(1, n - 1);
            feed_pixels(split);
            write_reg(CFG_THRESH, threshold_word());
            feed_pixels(n - split);
        end else begin
            feed_pixels(n);
        end
    endtask

    task automatic random_phase(input t_idle_mode m);
        int start;
        set_mode(m);
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PER_MODE) random_segment();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 frame, threshold 0: only one pixel differs, so the corners far
        // from it stay flat and its neighbors become edges
        write_reg(CFG_WIDTH, 13'd3);
        write_reg(CFG_HEIGHT, 13'd3);
        write_reg(CFG_THRESH, 13'd0);
        repeat (8) push_pixel(24'h123456);
        push_pixel(24'h123457);

        // zero sizes read as 1x1; negative threshold marks everything
        write_reg(CFG_WIDTH, 13'd0);
        write_reg(CFG_HEIGHT, 13'd0);
        write_reg(CFG_THRESH, {3'b000, 10'h3FF});
        push_pixel(24'hFFFFFF);
        push_pixel(24'h000000);

        // black vs white is 441.67 apart: edge at 440, flat at 441
        write_reg(CFG_WIDTH, 13'd2);
        write_reg(CFG_HEIGHT, 13'd2);
        write_reg(CFG_THRESH, 13'd440);
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        push_pixel(24'hFFFFFF);
        push_pixel(24'h000000);
        write_reg(CFG_THRESH, 13'd441);
        push_pixel(24'h000000);
        push_pixel(24'hFFFFFF);
        push_pixel(24'hFFFFFF);
        push_pixel(24'h000000);

        // width with the unused top data bit set; one row, top threshold
        write_reg(CFG_WIDTH, 13'h1004);
        write_reg(CFG_HEIGHT, 13'd1);
        write_reg(CFG_THRESH, 13'd511);
        push_pixel(24'hFF0000);
        push_pixel(24'h00FF00);
        push_pixel(24'h0000FF);
        push_pixel(24'hFFFFFF);

        // most negative threshold on a single column
        write_reg(CFG_WIDTH, 13'd1);
        write_reg(CFG_HEIGHT, 13'd2);
        write_reg(CFG_THRESH, {3'b111, 10'h200});
        push_pixel(24'h808080);
        push_pixel(24'h808080);

        // oversized writes saturate: the start of one maximal row, then the
        // start of a maximal single column, each cut off by the next write
        write_reg(CFG_WIDTH, 13'h0FFF);
        write_reg(CFG_HEIGHT, 13'd1);
        write_reg(CFG_THRESH, threshold_word());
        feed_pixels(SAT_PIXELS);
        write_reg(CFG_WIDTH, 13'd1);
        write_reg(CFG_HEIGHT, 13'h1FFF);
        feed_pixels(SAT_PIXELS);

        // random frames under every idling pattern
        random_phase(IDLE_NONE);
        random_phase(IDLE_SEND);
        random_phase(IDLE_RECV);
        random_phase(IDLE_BOTH);

        // pressure: receiver holds off while the sender keeps offering
        write_reg(CFG_WIDTH, 13'd8);
        write_reg(CFG_HEIGHT, 13'd6);
        write_reg(CFG_THRESH, threshold_word());
        set_mode(IDLE_HOLD);
        feed_pixels(48);

        wait_idle();
        if (mismatch_count == 0 && edge_results.size() == 0)
            $display("rgb_neighborhood_edge_detect regression: pass");
        else
            $display("rgb_neighborhood_edge_detect regression: fail");
        $finish;
    end

endmodule
